// ===== rtl/core/upds_pkg.sv =====
// Package for the UDP socket table: sizes, codes and the structs shared by the
// socket cells, the payload memory and the top level. No dependencies.
package upds_pkg;

	localparam int NUM_SOCKETS        = 8;
	localparam int BUFFER_BYTES       = 512;
	localparam int BANK_COUNT         = NUM_SOCKETS + 1;
	localparam int SEND_PAYLOAD_LIMIT = 1472;
	localparam int SOCK_W             = 3;
	localparam int BANK_W             = 4;
	localparam int OFF_W              = 9;
	localparam int DLEN_W             = 10;
	localparam int MEM_DEPTH          = BANK_COUNT * BUFFER_BYTES;
	localparam int MEM_AW             = BANK_W + OFF_W;
	localparam int HDR_BYTES          = 8;

	typedef enum logic [2:0] {
		K_OPEN  = 3'd0,
		K_CLOSE = 3'd1,
		K_RECV  = 3'd2,
		K_SEND  = 3'd3,
		K_POLL  = 3'd4,
		K_READ  = 3'd5
	} kind_e;

	typedef enum logic [2:0] {
		S_OK        = 3'd0,
		S_NO_FREE   = 3'd1,
		S_CLOSED    = 3'd2,
		S_TOO_LARGE = 3'd3,
		S_NO_DATA   = 3'd4
	} status_e;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEND,
		ST_READ
	} state_e;

	typedef struct packed {
		logic [2:0]  kind;
		logic [2:0]  socket_index;
		logic [15:0] port;
		logic [7:0]  data_byte;
		logic        last_in;
		logic [31:0] source_address;
		logic [15:0] length;
		logic [8:0]  offset;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [2:0]  socket_out;
		logic [7:0]  byte_out;
		logic        last_out;
		logic [9:0]  data_length;
		logic [31:0] sender_address;
		logic [15:0] sender_port;
	} rsp_t;

	// command broadcast to every socket cell
	typedef struct packed {
		logic              do_open;
		logic              do_close;
		logic              do_poll;
		logic              do_commit;
		logic [15:0]       port;
		logic [15:0]       match_port;
		logic [DLEN_W-1:0] dlen;
		logic [31:0]       addr;
		logic [15:0]       sport;
	} cell_cmd_t;

	// priority chain passed from cell to cell, lowest index first
	typedef struct packed {
		logic free_found;
		logic match_found;
	} chain_t;

	typedef struct packed {
		logic              open;
		logic              ready;
		logic [15:0]       port;
		logic [DLEN_W-1:0] len;
		logic [31:0]       addr;
		logic [15:0]       sport;
		logic              took_open;
		logic              took_commit;
	} cell_view_t;

endpackage

// ===== rtl/core/upds_cell.sv =====
// One socket cell: port, open and ready bits and the stored datagram's details.
// Depends on upds_pkg.
module upds_cell (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  sel,
	input  upds_pkg::cell_cmd_t   cmd,
	input  upds_pkg::chain_t      chain_in,
	output upds_pkg::chain_t      chain_out,
	output upds_pkg::cell_view_t  view
);
	import upds_pkg::*;

	logic              open_q;
	logic              ready_q;
	logic [15:0]       port_q;
	logic [DLEN_W-1:0] len_q;
	logic [31:0]       addr_q;
	logic [15:0]       sport_q;
	logic              match;
	logic              take_open;
	logic              take_commit;

	assign match       = open_q && (port_q == cmd.match_port);
	assign take_open   = cmd.do_open && !open_q && !chain_in.free_found;
	assign take_commit = cmd.do_commit && match && !chain_in.match_found;

	assign chain_out.free_found  = chain_in.free_found | ~open_q;
	assign chain_out.match_found = chain_in.match_found | match;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q  <= 1'b0;
			ready_q <= 1'b0;
			port_q  <= '0;
			len_q   <= '0;
			addr_q  <= '0;
			sport_q <= '0;
		end else begin
			if (take_open) begin
				port_q  <= cmd.port;
				open_q  <= 1'b1;
				ready_q <= 1'b0;
			end
			if (cmd.do_close && sel)
				open_q <= 1'b0;
			if (cmd.do_poll && sel)
				ready_q <= 1'b0;
			if (take_commit) begin
				len_q   <= cmd.dlen;
				addr_q  <= cmd.addr;
				sport_q <= cmd.sport;
				ready_q <= 1'b1;
			end
		end
	end

	assign view.open        = open_q;
	assign view.ready       = ready_q;
	assign view.port        = port_q;
	assign view.len         = len_q;
	assign view.addr        = addr_q;
	assign view.sport       = sport_q;
	assign view.took_open   = take_open;
	assign view.took_commit = take_commit;

endmodule

// ===== rtl/core/upds_payload_ram.sv =====
// Payload memory: one buffer bank per socket plus a staging bank, one write
// and one registered read port. Depends on upds_pkg.
module upds_payload_ram (
	input  logic                      clk,
	input  logic                      we,
	input  logic [upds_pkg::MEM_AW-1:0] waddr,
	input  logic [7:0]                wdata,
	input  logic                      re,
	input  logic [upds_pkg::MEM_AW-1:0] raddr,
	output logic [7:0]                rdata
);
	import upds_pkg::*;

	logic [7:0] mem [MEM_DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		if (re)
			rdata <= mem[raddr];
	end

endmodule

// ===== rtl/core/udp_port_demux_socket_table.sv =====
// Top level of the UDP socket table: socket cell chain, payload memory,
// receive parser and the response sequencer. Depends on upds_pkg, upds_cell,
// upds_payload_ram.
//
// Usage:
//  - Requests enter on req/req_valid/req_ready, one item per handshake; the
//    kind field picks open, close, receive byte, send header, poll or read.
//  - Responses leave on rsp/rsp_valid/rsp_ready through one output register.
//  - Receive bytes give no response and are taken one per cycle while the
//    output register is free or being emptied; a datagram is committed to the
//    lowest open socket on its port with its last byte, in the same cycle.
//  - Open, close, poll and every error answer appear in the cycle after the
//    item is taken. A read byte passes through the registered read port of
//    the payload memory and then the output register. A send header gives
//    eight items on consecutive cycles when the receiver keeps up, and no new
//    request is taken until the eighth is loaded.
//  - One request is in flight at a time; throughput is one item per cycle for
//    receive bytes, open, close, poll and error answers while rsp_ready stays
//    high; a read or send holds off new requests until its last item loads.
//  - When the receiver stalls, the response is held unchanged and req_ready
//    drops until the output register can be refilled.
//  - Reset closes all sockets, clears ready bits and stored details, gives
//    socket i bank i and the spare bank to staging. The payload memory is not
//    cleared; reads are bounded by the stored length.
module udp_port_demux_socket_table (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  upds_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output upds_pkg::rsp_t rsp
);
	import upds_pkg::*;

	// socket cells
	cell_cmd_t  cmd;
	chain_t     chain [NUM_SOCKETS+1];
	cell_view_t views [NUM_SOCKETS];

	// bank ownership and receive parser
	logic [BANK_W-1:0] bank_q [NUM_SOCKETS];
	logic [BANK_W-1:0] staging_q;
	logic [15:0]       byte_cnt_q;
	logic [15:0]       hdr_sport_q;
	logic [15:0]       hdr_dport_q;
	logic [15:0]       hdr_len_q;

	// sequencer
	state_e    st_q, st_d;
	rsp_t      rsp_q, rsp_d;
	logic      rsp_valid_q;
	logic      load;
	logic [63:0] hdr_q, hdr_d;
	logic      hdr_ld, hdr_shift;
	logic [2:0] cnt_q, cnt_d;

	logic        out_free;
	logic        acc;
	logic        recv_acc;
	cell_view_t  sview;
	logic [SOCK_W-1:0] open_idx;
	logic [BANK_W-1:0] win_bank;
	logic        any_commit;
	logic [16:0] total;
	logic        len_ok;
	logic [15:0] dl_full;
	logic [DLEN_W-1:0] dlen;
	logic        pay_we;
	logic [15:0] pay_off;
	logic        ram_re;
	logic [7:0]  ram_rdata;
	logic [MEM_AW-1:0] raddr;
	logic [15:0] send_total;

	assign out_free  = !rsp_valid_q || rsp_ready;
	assign req_ready = (st_q == ST_IDLE) && out_free;
	assign acc       = req_valid && req_ready;
	assign recv_acc  = acc && (req.kind == K_RECV);
	assign sview     = views[req.socket_index];

	// Commit check on the final byte: total counts the byte now arriving.
	assign total   = {1'b0, byte_cnt_q} + 17'd1;
	assign len_ok  = (total >= 17'd8) && (hdr_len_q >= 16'd8) && ({1'b0, hdr_len_q} <= total);
	assign dl_full = hdr_len_q - 16'd8;
	assign dlen    = (dl_full > 16'(BUFFER_BYTES)) ? DLEN_W'(BUFFER_BYTES) : dl_full[DLEN_W-1:0];

	assign chain[0] = '0;

	for (genvar i = 0; i < NUM_SOCKETS; i++) begin : g_cell
		upds_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.sel       (req.socket_index == SOCK_W'(i)),
			.cmd       (cmd),
			.chain_in  (chain[i]),
			.chain_out (chain[i+1]),
			.view      (views[i])
		);
	end

	// Pick out the winners' index and bank; at most one cell wins each.
	always_comb begin
		open_idx   = '0;
		win_bank   = '0;
		any_commit = 1'b0;
		for (int i = 0; i < NUM_SOCKETS; i++) begin
			if (views[i].took_open)
				open_idx = open_idx | SOCK_W'(i);
			if (views[i].took_commit) begin
				win_bank   = win_bank | bank_q[i];
				any_commit = 1'b1;
			end
		end
	end

	// Swap the staging bank with the bank of the socket that takes the datagram.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SOCKETS; i++)
				bank_q[i] <= BANK_W'(i);
			staging_q <= BANK_W'(NUM_SOCKETS);
		end else if (any_commit) begin
			for (int i = 0; i < NUM_SOCKETS; i++)
				if (views[i].took_commit)
					bank_q[i] <= staging_q;
			staging_q <= win_bank;
		end
	end

	// Receive parser: header bytes into registers, payload into staging bank.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_cnt_q  <= '0;
			hdr_sport_q <= '0;
			hdr_dport_q <= '0;
			hdr_len_q   <= '0;
		end else if (recv_acc) begin
			case (byte_cnt_q)
				16'd0: hdr_sport_q[15:8] <= req.data_byte;
				16'd1: hdr_sport_q[7:0]  <= req.data_byte;
				16'd2: hdr_dport_q[15:8] <= req.data_byte;
				16'd3: hdr_dport_q[7:0]  <= req.data_byte;
				16'd4: hdr_len_q[15:8]   <= req.data_byte;
				16'd5: hdr_len_q[7:0]    <= req.data_byte;
				default: ;
			endcase
			if (req.last_in)
				byte_cnt_q <= '0;
			else if (byte_cnt_q != 16'hFFFF)
				byte_cnt_q <= byte_cnt_q + 16'd1;
		end
	end

	assign pay_off = byte_cnt_q - 16'd8;
	assign pay_we  = recv_acc && (byte_cnt_q >= 16'd8) && (pay_off < 16'(BUFFER_BYTES));
	assign raddr   = {bank_q[req.socket_index], req.offset};

	upds_payload_ram u_ram (
		.clk   (clk),
		.we    (pay_we),
		.waddr ({staging_q, pay_off[OFF_W-1:0]}),
		.wdata (req.data_byte),
		.re    (ram_re),
		.raddr (raddr),
		.rdata (ram_rdata)
	);

	assign send_total = req.length + 16'd8;

	// Sequencer: next state, cell commands and the response to load.
	always_comb begin
		st_d      = st_q;
		cnt_d     = cnt_q;
		load      = 1'b0;
		hdr_ld    = 1'b0;
		hdr_shift = 1'b0;
		hdr_d     = hdr_q;
		ram_re    = 1'b0;
		rsp_d     = '0;
		rsp_d.last_out = 1'b1;
		cmd       = '0;
		cmd.port       = req.port;
		cmd.match_port = hdr_dport_q;
		cmd.dlen       = dlen;
		cmd.addr       = req.source_address;
		cmd.sport      = hdr_sport_q;
		case (st_q)
			ST_IDLE: begin
				if (acc) begin
					case (req.kind)
						K_OPEN: begin
							cmd.do_open = 1'b1;
							load = 1'b1;
							if (chain[NUM_SOCKETS].free_found) begin
								rsp_d.status     = S_OK;
								rsp_d.socket_out = open_idx;
							end else begin
								rsp_d.status = S_NO_FREE;
							end
						end
						K_CLOSE: begin
							cmd.do_close = 1'b1;
							load = 1'b1;
							rsp_d.status = S_OK;
						end
						K_RECV: begin
							cmd.do_commit = req.last_in && len_ok;
						end
						K_SEND: begin
							load = 1'b1;
							if (!sview.open) begin
								rsp_d.status = S_CLOSED;
							end else if (req.length > 16'(SEND_PAYLOAD_LIMIT)) begin
								rsp_d.status = S_TOO_LARGE;
							end else begin
								rsp_d.byte_out = sview.port[15:8];
								rsp_d.last_out = 1'b0;
								hdr_ld = 1'b1;
								hdr_d  = {sview.port[7:0], req.port, send_total, 16'h0000, 8'h00};
								cnt_d  = 3'd1;
								st_d   = ST_SEND;
							end
						end
						K_POLL: begin
							load = 1'b1;
							if (!sview.open) begin
								rsp_d.status = S_CLOSED;
							end else if (!sview.ready) begin
								rsp_d.status = S_NO_DATA;
							end else begin
								cmd.do_poll = 1'b1;
								rsp_d.status = S_OK;
								rsp_d.data_length = ({6'd0, sview.len} > req.length) ?
									req.length[DLEN_W-1:0] : sview.len;
								rsp_d.sender_address = sview.addr;
								rsp_d.sender_port    = sview.sport;
							end
						end
						K_READ: begin
							if (!sview.open) begin
								load = 1'b1;
								rsp_d.status = S_CLOSED;
							end else if ({1'b0, req.offset} >= sview.len) begin
								load = 1'b1;
								rsp_d.status = S_NO_DATA;
							end else begin
								ram_re = 1'b1;
								st_d   = ST_READ;
							end
						end
						default: ;
					endcase
				end
			end
			ST_SEND: begin
				if (out_free) begin
					load = 1'b1;
					hdr_shift = 1'b1;
					rsp_d.byte_out = hdr_q[63:56];
					rsp_d.last_out = (cnt_q == 3'(HDR_BYTES - 1));
					cnt_d = cnt_q + 3'd1;
					if (cnt_q == 3'(HDR_BYTES - 1))
						st_d = ST_IDLE;
				end
			end
			ST_READ: begin
				if (out_free) begin
					load = 1'b1;
					rsp_d.byte_out = ram_rdata;
					st_d = ST_IDLE;
				end
			end
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			rsp_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			st_q  <= st_d;
			cnt_q <= cnt_d;
			if (load)
				rsp_valid_q <= 1'b1;
			else if (rsp_ready)
				rsp_valid_q <= 1'b0;
		end
	end

	// Hold payload registers; shift the send header one byte per item.
	always_ff @(posedge clk) begin
		if (load)
			rsp_q <= rsp_d;
		if (hdr_ld)
			hdr_q <= hdr_d;
		else if (hdr_shift)
			hdr_q <= {hdr_q[55:0], 8'h00};
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ===== rtl/core/upds_checker.sv =====
// Port-level checker for the UDP socket table, bound to the top level.
// Depends on upds_pkg and udp_port_demux_socket_table.
module upds_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           req_ready,
	input logic           rsp_valid,
	input logic           rsp_ready,
	input upds_pkg::rsp_t rsp
);
	import upds_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	a_mid_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.last_out |-> rsp.status == S_OK && rsp.data_length == '0)
		else $error("header byte carries error or length");

	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != S_OK |-> rsp.last_out)
		else $error("error answer not marked last");

	a_send_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.last_out |-> !req_ready)
		else $error("request taken during header run");

endmodule

bind udp_port_demux_socket_table upds_checker u_upds_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_ready (req_ready),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);
